@@ rtl/core/voxel_segment_hash_store_unit_assert.svh @@
// Assertion macros shared by the RTL that checks itself.
`ifndef VOXEL_SEGMENT_HASH_STORE_UNIT_ASSERT_SVH
`define VOXEL_SEGMENT_HASH_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define VSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define VSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/vsh_pkg.sv @@
package vsh_pkg;

    localparam int TABLE_SLOTS    = 64;
    localparam int OVERFLOW_SLOTS = 64;
    localparam int TOTAL_SLOTS    = TABLE_SLOTS + OVERFLOW_SLOTS;
    localparam int HASH_W         = 6;
    localparam int SLOT_W         = 7;
    localparam int COUNT_W        = 8;
    localparam int COORD_W        = 24;
    localparam int OFS_W          = 4;
    localparam int GRID_W         = COORD_W - OFS_W;
    localparam int ZZ_W           = GRID_W + 1;
    localparam int KEY_W          = 3 * GRID_W;
    localparam int BLK_ADDR_W     = SLOT_W + 3 * OFS_W;
    localparam int BLOCK_W        = 8;
    localparam int STATUS_W       = 3;
    localparam int OP_W           = 2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND   = 3'd0,
        STAT_CREATED = 3'd1,
        STAT_MISSING = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_RANGE   = 3'd4
    } t_status;

    typedef enum logic [OP_W-1:0] {
        OP_FIND  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_LOOK,
        S_CMP,
        S_BLK,
        S_BLKD,
        S_FIN
    } t_state;

    function automatic logic [ZZ_W-1:0] zigzag(input logic [GRID_W-1:0] v);
        zigzag = {v, 1'b0} ^ {ZZ_W{v[GRID_W-1]}};
    endfunction

endpackage

@@ rtl/core/voxel_segment_hash_store_unit.sv @@
// Sparse voxel store: 128 segments of 16x16x16 blocks, found through a 64-slot
// chained hash table with 64 overflow slots. One item is in flight at a time.
// A find/create passes through two hash states, then one key/next memory read
// and compare per chain link visited; a block write or read adds the block
// memory access. The result then goes to the output register once that is
// free or being read; it can hold a finished result while the next item is
// accepted. Segment keys and chain links sit in synchronous memories; slot
// valid and has-next bits are flip-flops cleared by reset, so no clearing
// pass is needed. Block contents are undefined until written.
module voxel_segment_hash_store_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [vsh_pkg::OP_W-1:0]      i_op,
    input  logic signed [vsh_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vsh_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vsh_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vsh_pkg::BLOCK_W-1:0]   i_block_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vsh_pkg::STATUS_W-1:0]  o_status,
    output logic [vsh_pkg::BLOCK_W-1:0]   o_block_out,
    output logic [vsh_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [vsh_pkg::COUNT_W-1:0]   o_segment_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vsh_pkg::BLOCK_W-1:0]   i_cfg_data
);

    localparam int GW = vsh_pkg::GRID_W;
    localparam int HW = vsh_pkg::HASH_W;
    localparam int SW = vsh_pkg::SLOT_W;
    localparam int OW = vsh_pkg::OFS_W;
    localparam int BW = vsh_pkg::BLOCK_W;
    localparam int CW = vsh_pkg::COUNT_W;
    localparam int ZW = vsh_pkg::ZZ_W;

    vsh_pkg::t_state r_state, n_state;

    vsh_pkg::t_op    r_op;
    logic [GW-1:0]   r_gx, r_gy, r_gz;
    logic [OW-1:0]   r_ox, r_oy, r_oz;
    logic [BW-1:0]   r_bval;
    logic [BW-1:0]   r_empty_code;

    logic [HW-1:0]   r_m6, r_m2, r_mz2, r_z6, r_xy2, r_tail6;
    logic [HW-1:0]   r_head;
    logic [SW-1:0]   r_idx, n_idx;

    logic [CW-1:0]   r_nfo;
    logic [CW-1:0]   r_seg_count;

    logic [vsh_pkg::TOTAL_SLOTS-1:0] r_slot_valid;
    logic [vsh_pkg::TOTAL_SLOTS-1:0] r_slot_has_next;

    logic [vsh_pkg::KEY_W-1:0] r_key_mem  [vsh_pkg::TOTAL_SLOTS];
    logic [SW-1:0]             r_next_mem [vsh_pkg::TOTAL_SLOTS];
    logic [BW-1:0]             r_block_mem[2**vsh_pkg::BLK_ADDR_W];
    logic [vsh_pkg::KEY_W-1:0] r_key_q;
    logic [SW-1:0]             r_next_q;
    logic [BW-1:0]             r_blk_q;

    vsh_pkg::t_status r_res_status, n_res_status;
    logic [BW-1:0]    r_res_blk, n_res_blk;
    logic [SW-1:0]    r_res_slot, n_res_slot;

    logic                     r_o_valid;
    vsh_pkg::t_status         r_o_status;
    logic [BW-1:0]            r_o_blk;
    logic [SW-1:0]            r_o_slot;
    logic [CW-1:0]            r_o_total;

    logic                     accept;
    logic                     grid_ok;
    logic [vsh_pkg::KEY_W-1:0] key;
    logic                     hit;
    logic                     claim_en;
    logic [SW-1:0]            claim_slot;
    logic                     link_en;
    logic                     blk_we;
    logic                     out_load;
    logic [vsh_pkg::BLK_ADDR_W-1:0] blk_addr;

    logic [ZW-1:0] zx, zy, zz, zm1, zm;
    logic [HW-1:0] h6;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == vsh_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign key         = {r_gx, r_gy, r_gz};
    assign hit         = r_slot_valid[r_idx] && (r_key_q == key);
    assign blk_addr    = {r_idx, r_ox, r_oy, r_oz};

    // Grid coordinate of a find must fit the signed grid width.
    assign grid_ok = (i_coord_x[vsh_pkg::COORD_W-1:GW-1] == {(OW+1){i_coord_x[GW-1]}})
                  && (i_coord_y[vsh_pkg::COORD_W-1:GW-1] == {(OW+1){i_coord_y[GW-1]}})
                  && (i_coord_z[vsh_pkg::COORD_W-1:GW-1] == {(OW+1){i_coord_z[GW-1]}});

    // Hash, first half: zigzag, maxima and the partial products mod 64.
    always_comb begin
        zx  = vsh_pkg::zigzag(r_gx);
        zy  = vsh_pkg::zigzag(r_gy);
        zz  = vsh_pkg::zigzag(r_gz);
        zm1 = (zx > zy) ? zx : zy;
        zm  = (zz > zm1) ? zz : zm1;
    end

    assign h6 = HW'(r_m2 * r_m6) + r_mz2 + r_z6 + r_xy2 + r_tail6;

    always_ff @(posedge i_clk) begin
        if (r_state == vsh_pkg::S_HASH1) begin
            r_m6    <= zm[HW-1:0];
            r_m2    <= HW'(zm[HW-1:0] * zm[HW-1:0]);
            r_mz2   <= HW'({zm[HW-1:0] * zz[HW-1:0], 1'b0});
            r_z6    <= zz[HW-1:0];
            r_xy2   <= (zm == zz) ? HW'(zm1[HW-1:0] * zm1[HW-1:0]) : '0;
            r_tail6 <= (zy >= zx) ? HW'(zx[HW-1:0] + zy[HW-1:0]) : zy[HW-1:0];
        end
        if (r_state == vsh_pkg::S_HASH2) begin
            r_head <= h6;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= vsh_pkg::t_op'(i_op);
            r_bval <= i_block_value;
            if (vsh_pkg::t_op'(i_op) == vsh_pkg::OP_FIND) begin
                r_gx <= i_coord_x[GW-1:0];
                r_gy <= i_coord_y[GW-1:0];
                r_gz <= i_coord_z[GW-1:0];
            end else begin
                r_gx <= i_coord_x[vsh_pkg::COORD_W-1:OW];
                r_gy <= i_coord_y[vsh_pkg::COORD_W-1:OW];
                r_gz <= i_coord_z[vsh_pkg::COORD_W-1:OW];
            end
            r_ox <= i_coord_x[OW-1:0];
            r_oy <= i_coord_y[OW-1:0];
            r_oz <= i_coord_z[OW-1:0];
        end
    end

    // Next state and table control
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_blk    = r_res_blk;
        n_res_slot   = r_res_slot;
        claim_en     = 1'b0;
        claim_slot   = r_idx;
        link_en      = 1'b0;
        blk_we       = 1'b0;
        out_load     = 1'b0;
        case (r_state)
            vsh_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_blk  = '0;
                    n_res_slot = '0;
                    if ((vsh_pkg::t_op'(i_op) == vsh_pkg::OP_NONE) ||
                        ((vsh_pkg::t_op'(i_op) == vsh_pkg::OP_FIND) && !grid_ok)) begin
                        n_res_status = vsh_pkg::STAT_RANGE;
                        n_state      = vsh_pkg::S_FIN;
                    end else begin
                        n_state = vsh_pkg::S_HASH1;
                    end
                end
            end
            vsh_pkg::S_HASH1: n_state = vsh_pkg::S_HASH2;
            vsh_pkg::S_HASH2: begin
                n_idx   = {1'b0, h6};
                n_state = vsh_pkg::S_LOOK;
            end
            vsh_pkg::S_LOOK: n_state = vsh_pkg::S_CMP;
            vsh_pkg::S_CMP: begin
                if (hit) begin
                    if (r_op == vsh_pkg::OP_FIND) begin
                        n_res_status = vsh_pkg::STAT_FOUND;
                        n_res_slot   = r_idx;
                        n_state      = vsh_pkg::S_FIN;
                    end else begin
                        n_state = vsh_pkg::S_BLK;
                    end
                end else if (r_slot_has_next[r_idx]) begin
                    // follow the chain
                    n_idx   = r_next_q;
                    n_state = vsh_pkg::S_LOOK;
                end else if (r_op == vsh_pkg::OP_FIND) begin
                    n_state = vsh_pkg::S_FIN;
                    if (!r_slot_valid[{1'b0, r_head}]) begin
                        claim_en     = 1'b1;
                        claim_slot   = {1'b0, r_head};
                        n_res_status = vsh_pkg::STAT_CREATED;
                        n_res_slot   = {1'b0, r_head};
                    end else if (r_nfo >= CW'(vsh_pkg::TOTAL_SLOTS)) begin
                        n_res_status = vsh_pkg::STAT_FULL;
                    end else begin
                        // r_idx is the chain tail: link a fresh overflow slot
                        link_en      = 1'b1;
                        claim_en     = 1'b1;
                        claim_slot   = r_nfo[SW-1:0];
                        n_res_status = vsh_pkg::STAT_CREATED;
                        n_res_slot   = r_nfo[SW-1:0];
                    end
                end else begin
                    n_res_status = vsh_pkg::STAT_MISSING;
                    n_res_blk    = (r_op == vsh_pkg::OP_READ) ? r_empty_code : '0;
                    n_state      = vsh_pkg::S_FIN;
                end
            end
            vsh_pkg::S_BLK: begin
                n_res_status = vsh_pkg::STAT_FOUND;
                n_res_slot   = r_idx;
                if (r_op == vsh_pkg::OP_WRITE) begin
                    blk_we  = 1'b1;
                    n_state = vsh_pkg::S_FIN;
                end else begin
                    n_state = vsh_pkg::S_BLKD;
                end
            end
            vsh_pkg::S_BLKD: begin
                n_res_blk = r_blk_q;
                n_state   = vsh_pkg::S_FIN;
            end
            vsh_pkg::S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = vsh_pkg::S_IDLE;
                end
            end
            default: n_state = vsh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= vsh_pkg::S_IDLE;
            r_slot_valid    <= '0;
            r_slot_has_next <= '0;
            r_nfo           <= CW'(vsh_pkg::TABLE_SLOTS);
            r_seg_count     <= '0;
            r_empty_code    <= '0;
            r_o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_empty_code <= i_cfg_data;
            end
            if (link_en) begin
                r_slot_has_next[r_idx] <= 1'b1;
                r_nfo                  <= r_nfo + 1'b1;
            end
            if (claim_en) begin
                r_slot_valid[claim_slot]    <= 1'b1;
                r_slot_has_next[claim_slot] <= 1'b0;
                r_seg_count                 <= r_seg_count + 1'b1;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_blk    <= n_res_blk;
        r_res_slot   <= n_res_slot;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_blk    <= r_res_blk;
            r_o_slot   <= r_res_slot;
            r_o_total  <= r_seg_count;
        end
    end

    // Key and link memories
    always_ff @(posedge i_clk) begin
        if (claim_en) begin
            r_key_mem[claim_slot] <= key;
        end
        if (link_en) begin
            r_next_mem[r_idx] <= r_nfo[SW-1:0];
        end
        r_key_q  <= r_key_mem[r_idx];
        r_next_q <= r_next_mem[r_idx];
    end

    // Block memory
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_block_mem[blk_addr] <= r_bval;
        end
        r_blk_q <= r_block_mem[blk_addr];
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_block_out     = r_o_blk;
    assign o_slot_index    = r_o_slot;
    assign o_segment_total = r_o_total;

`include "voxel_segment_hash_store_unit_assert.svh"

    `VSH_ASSERT_NOW(a_nfo_range, 1'b1,
        (r_nfo >= CW'(vsh_pkg::TABLE_SLOTS)) && (r_nfo <= CW'(vsh_pkg::TOTAL_SLOTS)),
        "overflow pointer out of range")
    `VSH_ASSERT_NEXT(a_accept_busy, accept, r_state != vsh_pkg::S_IDLE,
        "item accepted but unit stayed idle")
    `VSH_ASSERT_NOW(a_created_count, o_valid && (o_status == vsh_pkg::STAT_CREATED),
        o_segment_total != '0, "segment created with zero total")

endmodule

@@ tb/sv/voxel_segment_hash_store_unit_tb.sv @@
`timescale 1ns / 100ps

module voxel_segment_hash_store_unit_tb;

    localparam int XW  = vsh_pkg::COORD_W;
    localparam int GW  = vsh_pkg::GRID_W;
    localparam int OW  = vsh_pkg::OFS_W;
    localparam int SW  = vsh_pkg::SLOT_W;
    localparam int BW  = vsh_pkg::BLOCK_W;
    localparam int CW  = vsh_pkg::COUNT_W;
    localparam int ZW  = vsh_pkg::ZZ_W;
    localparam int HW  = vsh_pkg::HASH_W;
    localparam int KW  = vsh_pkg::KEY_W;
    localparam int OPW = vsh_pkg::OP_W;
    localparam int STW = vsh_pkg::STATUS_W;
    localparam int NSLOT = vsh_pkg::TOTAL_SLOTS;

    typedef struct {
        logic [STW-1:0] status;
        logic [BW-1:0]  block_out;
        logic [SW-1:0]  slot_index;
        logic [CW-1:0]  segment_total;
    } t_answer;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [OPW-1:0] i_op;
    logic signed [XW-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic [BW-1:0] i_block_value;
    logic [STW-1:0] o_status;
    logic [BW-1:0] o_block_out;
    logic [SW-1:0] o_slot_index;
    logic [CW-1:0] o_segment_total;
    logic i_cfg_valid, o_cfg_ready;
    logic [BW-1:0] i_cfg_data;

    voxel_segment_hash_store_unit dut (.*);

    // shadow of the store
    logic             seg_used [NSLOT];
    logic [KW-1:0]    seg_key [NSLOT];
    logic             seg_linked [NSLOT];
    logic [SW-1:0]    seg_link [NSLOT];
    int unsigned      free_overflow;
    int unsigned      seg_made;
    logic [BW-1:0]    empty_code;
    logic [BW-1:0]    voxel_mem [int];

    t_answer answer_q[$];
    int errors;
    longint unsigned cycles;
    int send_idle_pct, recv_idle_pct;
    int hold_off;
    // grids created so far, used to aim block accesses at existing segments
    logic [GW-1:0] known_gx[$], known_gy[$], known_gz[$];
    // written block addresses, so reads stay on written entries
    logic [XW-1:0] wr_x[$], wr_y[$], wr_z[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [ZW-1:0] fold(logic [GW-1:0] v);
        longint s;
        s = longint'($signed(v));
        return (s >= 0) ? ZW'(s * 2) : ZW'(-s * 2 - 1);
    endfunction

    function automatic logic [HW-1:0] head_of(logic [GW-1:0] gx, logic [GW-1:0] gy,
                                              logic [GW-1:0] gz);
        longint unsigned x, y, z, m, xy, h;
        x = 64'(fold(gx)); y = 64'(fold(gy)); z = 64'(fold(gz));
        m = (x > y) ? x : y;
        xy = m;
        if (z > m) m = z;
        h = m * m * m + 2 * m * z + z;
        if (m == z) h += xy * xy;
        if (y >= x) h += x + y;
        else h += y;
        return h[HW-1:0];
    endfunction

    function automatic int find_seg(logic [GW-1:0] gx, logic [GW-1:0] gy,
                                    logic [GW-1:0] gz);
        int i;
        i = int'(head_of(gx, gy, gz));
        for (int n = 0; n <= NSLOT; n++) begin
            if (seg_used[i] && seg_key[i] == {gx, gy, gz}) return i;
            if (!seg_linked[i]) return -1;
            i = int'(seg_link[i]);
        end
        return -1;
    endfunction

    function automatic void take_slot(int i, logic [KW-1:0] key);
        seg_used[i] = 1'b1;
        seg_key[i] = key;
        seg_linked[i] = 1'b0;
        seg_made++;
    endfunction

    function automatic bit grid_fits(logic signed [XW-1:0] v);
        return v >= -(1 <<< (GW - 1)) && v < (1 <<< (GW - 1));
    endfunction

    function automatic t_answer predict_store(logic [OPW-1:0] op, logic signed [XW-1:0] cx,
            logic signed [XW-1:0] cy, logic signed [XW-1:0] cz, logic [BW-1:0] bv);
        t_answer a;
        int f, h, i, addr;
        a.status = vsh_pkg::STAT_RANGE; a.block_out = '0; a.slot_index = '0;
        if (op == vsh_pkg::OP_FIND) begin
            if (grid_fits(cx) && grid_fits(cy) && grid_fits(cz)) begin
                f = find_seg(cx[GW-1:0], cy[GW-1:0], cz[GW-1:0]);
                h = int'(head_of(cx[GW-1:0], cy[GW-1:0], cz[GW-1:0]));
                if (f >= 0) begin
                    a.status = vsh_pkg::STAT_FOUND; a.slot_index = SW'(f);
                end else if (!seg_used[h]) begin
                    take_slot(h, {cx[GW-1:0], cy[GW-1:0], cz[GW-1:0]});
                    a.status = vsh_pkg::STAT_CREATED; a.slot_index = SW'(h);
                end else if (free_overflow >= NSLOT) begin
                    a.status = vsh_pkg::STAT_FULL;
                end else begin
                    i = h;
                    while (seg_linked[i]) i = int'(seg_link[i]);
                    seg_linked[i] = 1'b1;
                    seg_link[i] = SW'(free_overflow);
                    take_slot(int'(free_overflow), {cx[GW-1:0], cy[GW-1:0], cz[GW-1:0]});
                    a.status = vsh_pkg::STAT_CREATED; a.slot_index = SW'(free_overflow);
                    free_overflow++;
                end
            end
        end else if (op == vsh_pkg::OP_WRITE || op == vsh_pkg::OP_READ) begin
            f = find_seg(cx[XW-1:OW], cy[XW-1:OW], cz[XW-1:OW]);
            if (f < 0) begin
                a.status = vsh_pkg::STAT_MISSING;
                if (op == vsh_pkg::OP_READ) a.block_out = empty_code;
            end else begin
                addr = int'({f[SW-1:0], cx[OW-1:0], cy[OW-1:0], cz[OW-1:0]});
                a.status = vsh_pkg::STAT_FOUND; a.slot_index = SW'(f);
                if (op == vsh_pkg::OP_WRITE) voxel_mem[addr] = bv;
                else a.block_out = voxel_mem.exists(addr) ? voxel_mem[addr] : '0;
            end
        end
        a.segment_total = CW'(seg_made);
        return a;
    endfunction

    // write-side bookkeeping so random reads only reach written blocks
    function automatic bit block_written(logic signed [XW-1:0] x,
            logic signed [XW-1:0] y, logic signed [XW-1:0] z);
        int f;
        f = find_seg(x[XW-1:OW], y[XW-1:OW], z[XW-1:OW]);
        if (f < 0) return 1'b1;
        return voxel_mem.exists(int'({f[SW-1:0], x[OW-1:0], y[OW-1:0], z[OW-1:0]}));
    endfunction

    task automatic send_item(logic [OPW-1:0] op, logic signed [XW-1:0] x,
            logic signed [XW-1:0] y, logic signed [XW-1:0] z,
            logic [BW-1:0] bv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        // a read of an unwritten block in an existing segment is turned into a write
        if (op == vsh_pkg::OP_READ && !block_written(x, y, z)) op = vsh_pkg::OP_WRITE;
        i_valid <= 1'b1; i_op <= op;
        i_coord_x <= x; i_coord_y <= y; i_coord_z <= z; i_block_value <= bv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        answer_q.push_back(predict_store(op, x, y, z, bv));
        if (op == vsh_pkg::OP_FIND && answer_q[$].status == vsh_pkg::STAT_CREATED) begin
            known_gx.push_back(x[GW-1:0]);
            known_gy.push_back(y[GW-1:0]);
            known_gz.push_back(z[GW-1:0]);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_empty_code(logic [BW-1:0] v);
        drain_and_settle();
        i_cfg_valid <= 1'b1; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        empty_code = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                $error("result with none expected");
                errors++;
            end else begin
                e = answer_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_block_out !== e.block_out) begin
                    $error("block_out exp %0d got %0d", e.block_out, o_block_out); errors++;
                end
                if (o_slot_index !== e.slot_index) begin
                    $error("slot_index exp %0d got %0d", e.slot_index, o_slot_index); errors++;
                end
                if (o_segment_total !== e.segment_total) begin
                    $error("segment_total exp %0d got %0d", e.segment_total,
                           o_segment_total);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [XW-1:0] rand_coord();
        return XW'($urandom());
    endfunction

    function automatic logic signed [XW-1:0] small_grid();
        return XW'($signed(XW'($urandom_range(6))) - 3);
    endfunction

    task automatic test_directed();
        logic signed [XW-1:0] gmax, gmin;
        gmax = XW'((1 <<< (GW - 1)) - 1);
        gmin = XW'(-(1 <<< (GW - 1)));
        send_item(vsh_pkg::OP_READ, 5, 6, 7, 0);               // missing segment read
        send_item(vsh_pkg::OP_WRITE, 5, 6, 7, 8'h3c);          // missing segment write
        send_item(vsh_pkg::OP_FIND, 0, 0, 0, 0);
        send_item(vsh_pkg::OP_FIND, 0, 0, 0, 0);
        send_item(vsh_pkg::OP_FIND, gmax, gmin, gmax, 0);
        send_item(vsh_pkg::OP_FIND, gmin, gmax, gmin, 0);
        send_item(vsh_pkg::OP_FIND, XW'(gmax + 1), 0, 0, 0);   // grid out of range
        send_item(vsh_pkg::OP_FIND, 0, 0, XW'(gmin - 1), 0);
        send_item(vsh_pkg::OP_FIND, 24'sh7fffff, 24'sh800000, 0, 0);
        send_item(vsh_pkg::OP_WRITE, 15, 15, 15, 8'hff);
        send_item(vsh_pkg::OP_READ, 15, 15, 15, 0);
        send_item(vsh_pkg::OP_WRITE, 0, 0, 0, 8'h00);
        send_item(vsh_pkg::OP_READ, 0, 0, 0, 0);
        send_item(vsh_pkg::OP_WRITE, XW'(gmax * 16 + 15), XW'(gmin * 16),
                  XW'(gmax * 16 + 8), 8'ha5);
        send_item(vsh_pkg::OP_READ, XW'(gmax * 16 + 15), XW'(gmin * 16),
                  XW'(gmax * 16 + 8), 0);
        send_item(vsh_pkg::OP_READ, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 0);
        send_item(vsh_pkg::OP_NONE, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 8'hff);
        send_item(vsh_pkg::OP_NONE, 0, 0, 0, 0);
        send_item(vsh_pkg::OP_FIND, -1, -1, -1, 0);
        send_item(vsh_pkg::OP_WRITE, -1, -16, -17, 8'h5a);
        send_item(vsh_pkg::OP_READ, -1, -16, -17, 0);
    endtask

    task automatic test_random(int count);
        int k, sel;
        logic signed [XW-1:0] x, y, z;
        for (int n = 0; n < count; n++) begin
            sel = int'($urandom_range(99));
            if (sel < 25) begin
                send_item(vsh_pkg::OP_FIND, XW'(small_grid() * 37), small_grid(),
                          XW'(small_grid() * 11), 0);
            end else if (sel < 75 && known_gx.size() > 0) begin
                k = int'($urandom_range(known_gx.size() - 1));
                x = {known_gx[k], OW'($urandom())};
                y = {known_gy[k], OW'($urandom())};
                z = {known_gz[k], OW'($urandom())};
                if (wr_x.size() > 0 && $urandom_range(1)) begin
                    k = int'($urandom_range(wr_x.size() - 1));
                    send_item(vsh_pkg::OP_READ, wr_x[k], wr_y[k], wr_z[k], BW'($urandom()));
                end else begin
                    send_item(vsh_pkg::OP_WRITE, x, y, z, BW'($urandom()));
                    wr_x.push_back(x); wr_y.push_back(y); wr_z.push_back(z);
                end
            end else if (sel < 85) begin
                send_item(vsh_pkg::OP_FIND, rand_coord() >>> $urandom_range(4, 8),
                          rand_coord() >>> $urandom_range(4, 8), rand_coord(), 0);
            end else begin
                send_item(OPW'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord(),
                          BW'($urandom()));
            end
        end
    endtask

    task automatic test_fill_table();
        // many distinct finds drive the overflow region to exhaustion
        for (int n = 0; n < 160; n++)
            send_item(vsh_pkg::OP_FIND, XW'(n * 3 - 200), XW'(-n), XW'(n * 7), 0);
    endtask

    task automatic test_back_pressure();
        drain_and_settle();
        hold_off <= 300;
        for (int n = 0; n < 20; n++)
            send_item(vsh_pkg::OP_READ, rand_coord(), rand_coord(), rand_coord(), 0);
    endtask

    initial begin
        cycles = 0; errors = 0; hold_off = 0;
        free_overflow = vsh_pkg::TABLE_SLOTS; seg_made = 0; empty_code = '0;
        for (int i = 0; i < NSLOT; i++) begin
            seg_used[i] = 1'b0; seg_linked[i] = 1'b0;
        end
        send_idle_pct = 11; recv_idle_pct = 76;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_op = vsh_pkg::OP_FIND; i_coord_x = '0; i_coord_y = '0; i_coord_z = '0;
        i_block_value = '0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        write_empty_code(8'hff);
        send_item(vsh_pkg::OP_READ, 999, 999, 999, 0);
        test_random(300);
        send_idle_pct = 76; recv_idle_pct = 11;
        write_empty_code(8'h81);
        test_random(300);
        test_back_pressure();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_empty_code(8'h7e);
        test_fill_table();
        test_random(100);
        write_empty_code(8'h00);
        send_item(vsh_pkg::OP_READ, -999, 999, -999, 0);

        drain_and_settle();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
